[hdl/tpd_pkg.sv]
// Shared types, constants and helper functions for the triac phase dimmer.
`timescale 1ns / 1ps

package tpd_pkg;

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_ZERO_CROSS = 2'd0;
    localparam logic [1:0] OP_PHASE_TICK = 2'd1;
    localparam logic [1:0] OP_RAMP_TICK  = 2'd2;
    localparam logic [1:0] OP_WATCHDOG   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_RAMP_ENABLE  = 3'd0;
    localparam logic [2:0] REG_RAMP_SPEED   = 3'd1;
    localparam logic [2:0] REG_FIRE_START_1 = 3'd2;
    localparam logic [2:0] REG_FIRE_START_2 = 3'd3;
    localparam logic [2:0] REG_RELAY_DELAY  = 3'd4;

    // Timing constants
    localparam logic [7:0] OFF_LEVEL  = 8'd208;
    localparam logic [7:0] GATE_LIMIT = 8'd240;
    localparam logic [7:0] LOW_SPAN   = 8'd3;
    localparam logic [7:0] HIGH_GAP   = 8'd5;
    localparam logic [7:0] MISS_LIMIT = 8'd200;

    // One result item
    typedef struct packed {
        logic       led_level;
        logic       led_write;
        logic       relay_update;
        logic [7:0] drive_2;
        logic [7:0] drive_1;
        logic       gate_2;
        logic       gate_1;
    } result_t;

    // Conduction width from a ramp level: (208 - level) * 2, low eight bits; zero for level 0
    function automatic logic [7:0] width_of(input logic [7:0] level);
        logic [7:0] diff;
        begin
            diff = OFF_LEVEL - level;
            width_of = (level == 8'd0) ? 8'd0 : {diff[6:0], 1'b0};
        end
    endfunction

    // One step of a level toward its goal
    function automatic logic [7:0] step_toward(input logic [7:0] level,
                                               input logic [7:0] goal);
        begin
            if (level > goal) begin
                step_toward = level - 8'd1;
            end else if (level < goal) begin
                step_toward = level + 8'd1;
            end else begin
                step_toward = level;
            end
        end
    endfunction

    // Gate level after a phase tick for one channel
    function automatic logic fire_gate(input logic [15:0] count,
                                       input logic [7:0]  start,
                                       input logic [7:0]  drive,
                                       input logic        gate);
        logic [16:0] c;
        logic [16:0] s;
        logic [16:0] low_end;
        logic [16:0] high_start;
        begin
            c          = {1'b0, count};
            s          = {9'd0, start};
            low_end    = s + {9'd0, LOW_SPAN};
            high_start = s + {9'd0, HIGH_GAP} + {9'd0, drive};
            if (drive == 8'd0) begin
                fire_gate = gate;
            end else if (c >= s && c < low_end) begin
                fire_gate = 1'b0;
            end else if (c >= high_start && c <= {9'd0, GATE_LIMIT}) begin
                fire_gate = 1'b1;
            end else begin
                fire_gate = gate;
            end
        end
    endfunction

endpackage

[hdl/triac_phase_dimmer_core.sv]
// Two-channel phase-angle dimmer core: event handling, ramping and result register.
`timescale 1ns / 1ps

// Each input item is one timer event (zero cross, phase tick, ramp tick or
// watchdog tick, selected by s_tuser). The block takes one item per clock
// while the output is not stalled and updates its counters, levels and
// gates in the same cycle; the matching result item appears on the m_ side
// in the cycle after acceptance and is held in the output register until
// taken. A new item is accepted whenever the output register is empty or
// being drained, one item per cycle while m_tready keeps up. Configuration
// writes take effect at the clock edge on which cfg_wr_en is high.
module triac_phase_dimmer_core
    import tpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] target_1, [15:8] target_2, [16] led_blinking
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] gate_1, [1] gate_2, [9:2] drive_1,
                                   // [17:10] drive_2, [18] relay_update,
                                   // [19] led_write, [20] led_level
);

    // Configuration registers
    logic        ramp_enable_reg;
    logic [7:0]  ramp_speed_reg;
    logic [7:0]  fire_start_1_reg;
    logic [7:0]  fire_start_2_reg;
    logic [15:0] relay_delay_reg;

    // Dimmer state
    logic [15:0] phase_count_1_reg, phase_count_1_next;
    logic [15:0] phase_count_2_reg, phase_count_2_next;
    logic        gate_level_1_reg, gate_level_1_next;
    logic        gate_level_2_reg, gate_level_2_next;
    logic [7:0]  ramp_level_1_reg, ramp_level_1_next;
    logic [7:0]  ramp_level_2_reg, ramp_level_2_next;
    logic [7:0]  drive_width_1_reg, drive_width_1_next;
    logic [7:0]  drive_width_2_reg, drive_width_2_next;
    logic [7:0]  ramp_divider_reg, ramp_divider_next;
    logic [15:0] relay_wait_reg, relay_wait_next;
    logic        relay_armed_reg, relay_armed_next;
    logic [7:0]  missed_cross_reg, missed_cross_next;

    // Output register
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     result_next;

    // Unpacked input fields
    logic [1:0]  operation;
    logic [7:0]  target_1;
    logic [7:0]  target_2;
    logic        led_blinking;
    logic        in_accept;

    // Working values
    logic [7:0]  goal_1;
    logic [7:0]  goal_2;
    logic [7:0]  base_level_1;
    logic [7:0]  base_level_2;
    logic [7:0]  divider_inc;
    logic [15:0] wait_inc;
    logic [7:0]  miss_inc;
    logic        relay_strobe;
    logic        led_wr;
    logic        led_lvl;

    assign operation    = s_tuser;
    assign target_1     = s_tdata[7:0];
    assign target_2     = s_tdata[15:8];
    assign led_blinking = s_tdata[16];

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_reg};

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_enable_reg  <= 1'b1;
            ramp_speed_reg   <= 8'd1;
            fire_start_1_reg <= 8'd2;
            fire_start_2_reg <= 8'd2;
            relay_delay_reg  <= 16'd60;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_RAMP_ENABLE:  ramp_enable_reg  <= cfg_wdata[0];
                REG_RAMP_SPEED:   ramp_speed_reg   <= cfg_wdata[7:0];
                REG_FIRE_START_1: fire_start_1_reg <= cfg_wdata[7:0];
                REG_FIRE_START_2: fire_start_2_reg <= cfg_wdata[7:0];
                REG_RELAY_DELAY:  relay_delay_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Compute next state and result for the item at the input
    always_comb begin
        phase_count_1_next = phase_count_1_reg;
        phase_count_2_next = phase_count_2_reg;
        gate_level_1_next  = gate_level_1_reg;
        gate_level_2_next  = gate_level_2_reg;
        ramp_level_1_next  = ramp_level_1_reg;
        ramp_level_2_next  = ramp_level_2_reg;
        drive_width_1_next = drive_width_1_reg;
        drive_width_2_next = drive_width_2_reg;
        ramp_divider_next  = ramp_divider_reg;
        relay_wait_next    = relay_wait_reg;
        relay_armed_next   = relay_armed_reg;
        missed_cross_next  = missed_cross_reg;
        relay_strobe       = 1'b0;
        led_wr             = 1'b0;
        led_lvl            = 1'b0;

        goal_1       = (target_1 == 8'd0) ? OFF_LEVEL : target_1;
        goal_2       = (target_2 == 8'd0) ? OFF_LEVEL : target_2;
        base_level_1 = (target_1 == 8'd0) ? OFF_LEVEL : ramp_level_1_reg;
        base_level_2 = (target_2 == 8'd0) ? OFF_LEVEL : ramp_level_2_reg;
        divider_inc  = ramp_divider_reg + 8'd1;
        wait_inc     = relay_wait_reg + 16'd1;
        miss_inc     = missed_cross_reg + 8'd1;

        unique case (operation)
            OP_ZERO_CROSS: begin
                // Restart both phases and arm the relay delay
                gate_level_1_next  = 1'b1;
                gate_level_2_next  = 1'b1;
                phase_count_1_next = 16'd0;
                phase_count_2_next = 16'd0;
                if (!relay_armed_reg) begin
                    relay_wait_next  = 16'd0;
                    relay_armed_next = 1'b1;
                end
                missed_cross_next = 8'd0;
            end
            OP_PHASE_TICK: begin
                // Advance relay delay, then phase counters and gates
                if (relay_armed_reg) begin
                    relay_wait_next = wait_inc;
                    if (wait_inc >= relay_delay_reg) begin
                        relay_armed_next = 1'b0;
                        relay_strobe     = 1'b1;
                        led_wr           = !led_blinking;
                        led_lvl          = !led_blinking;
                    end
                end
                phase_count_1_next = phase_count_1_reg + 16'd1;
                phase_count_2_next = phase_count_2_reg + 16'd1;
                gate_level_1_next  = fire_gate(phase_count_1_next, fire_start_1_reg,
                                               drive_width_1_reg, gate_level_1_reg);
                gate_level_2_next  = fire_gate(phase_count_2_next, fire_start_2_reg,
                                               drive_width_2_reg, gate_level_2_reg);
            end
            OP_RAMP_TICK: begin
                // Force off on zero target, step levels when the divider expires
                ramp_level_1_next = base_level_1;
                ramp_level_2_next = base_level_2;
                if (ramp_enable_reg) begin
                    ramp_divider_next = divider_inc;
                    if (divider_inc >= ramp_speed_reg) begin
                        ramp_divider_next  = 8'd0;
                        ramp_level_1_next  = step_toward(base_level_1, goal_1);
                        ramp_level_2_next  = step_toward(base_level_2, goal_2);
                        drive_width_1_next = width_of(ramp_level_1_next);
                        drive_width_2_next = width_of(ramp_level_2_next);
                    end
                end
            end
            OP_WATCHDOG: begin
                // Count ticks without a zero cross; strobe past the limit
                missed_cross_next = miss_inc;
                if (miss_inc > MISS_LIMIT) begin
                    relay_strobe      = 1'b1;
                    led_wr            = !led_blinking;
                    missed_cross_next = 8'd0;
                end
            end
            default: ;
        endcase

        result_next.gate_1       = gate_level_1_next;
        result_next.gate_2       = gate_level_2_next;
        result_next.drive_1      = drive_width_1_next;
        result_next.drive_2      = drive_width_2_next;
        result_next.relay_update = relay_strobe;
        result_next.led_write    = led_wr;
        result_next.led_level    = led_lvl;
    end

    // Commit state on an accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_count_1_reg <= 16'd0;
            phase_count_2_reg <= 16'd0;
            gate_level_1_reg  <= 1'b1;
            gate_level_2_reg  <= 1'b1;
            ramp_level_1_reg  <= 8'd0;
            ramp_level_2_reg  <= 8'd0;
            drive_width_1_reg <= 8'd0;
            drive_width_2_reg <= 8'd0;
            ramp_divider_reg  <= 8'd0;
            relay_wait_reg    <= 16'd0;
            relay_armed_reg   <= 1'b0;
            missed_cross_reg  <= 8'd0;
        end else if (in_accept) begin
            phase_count_1_reg <= phase_count_1_next;
            phase_count_2_reg <= phase_count_2_next;
            gate_level_1_reg  <= gate_level_1_next;
            gate_level_2_reg  <= gate_level_2_next;
            ramp_level_1_reg  <= ramp_level_1_next;
            ramp_level_2_reg  <= ramp_level_2_next;
            drive_width_1_reg <= drive_width_1_next;
            drive_width_2_reg <= drive_width_2_next;
            ramp_divider_reg  <= ramp_divider_next;
            relay_wait_reg    <= relay_wait_next;
            relay_armed_reg   <= relay_armed_next;
            missed_cross_reg  <= missed_cross_next;
        end
    end

    // Hold the result item until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_reg <= result_next;
        end
    end

    // An LED write always comes with a relay strobe
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.led_write) |-> out_reg.relay_update)
        else $error("led write without relay strobe");

    // The LED is only lit through a write
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.led_level) |-> out_reg.led_write)
        else $error("led level set without led write");

    // Gates only move when an item is accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_accept |=> ($stable(gate_level_1_reg) && $stable(gate_level_2_reg)))
        else $error("gate level changed without an item");

    // A relay strobe on a phase tick disarms the delay
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && operation == OP_PHASE_TICK && relay_strobe) |=> !relay_armed_reg)
        else $error("relay still armed after strobe");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the triac phase dimmer core: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import tpd_pkg::*;

    localparam int unsigned LONG_HOLD   = 150;
    localparam int unsigned DRAIN_LIMIT = 5000;
    localparam int unsigned MAX_SHOWN   = 10;
    localparam int          N_DIRECTED  = 23;

    // One row of the directed table; want is used only when fixed is set
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] tgt_1;
        logic [7:0] tgt_2;
        logic       blink;
        logic       fixed;
        result_t    want;
    } stim_row_t;

    // Gates high, nothing driven, no strobe
    localparam result_t QUIET = '{1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b1, 1'b1};

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr  = REG_RAMP_ENABLE;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = OP_ZERO_CROSS;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;

    // Dimmer state as predicted
    logic [15:0] dim_count_1     = '0;
    logic [15:0] dim_count_2     = '0;
    logic        dim_gate_1      = 1'b1;
    logic        dim_gate_2      = 1'b1;
    logic [7:0]  dim_level_1     = '0;
    logic [7:0]  dim_level_2     = '0;
    logic [7:0]  dim_drive_1     = '0;
    logic [7:0]  dim_drive_2     = '0;
    logic [7:0]  dim_ramp_div    = '0;
    logic [15:0] dim_relay_wait  = '0;
    logic        dim_relay_armed = 1'b0;
    logic [7:0]  dim_missed      = '0;

    // Register values as last written
    logic        set_ramp_en     = 1'b1;
    logic [7:0]  set_ramp_speed  = 8'd1;
    logic [7:0]  set_fire_1      = 8'd2;
    logic [7:0]  set_fire_2      = 8'd2;
    logic [15:0] set_relay_delay = 16'd60;

    result_t     results_due[$];
    result_t     seen_result;
    result_t     oldest_result;
    int unsigned mismatches = 0;

    // Traffic shaping
    bit          tx_gaps   = 1'b1;
    logic        rx_stalls = 1'b1;
    logic        hold_req  = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned rx_hold   = 0;

    stim_row_t directed [N_DIRECTED] = '{
        // after reset nothing moves
        '{OP_WATCHDOG,   8'd0,   8'd0,   1'b0, 1'b1, QUIET},
        // zero drive leaves the gates alone, relay not armed yet
        '{OP_PHASE_TICK, 8'd0,   8'd0,   1'b1, 1'b1, QUIET},
        '{OP_ZERO_CROSS, 8'd255, 8'd255, 1'b1, 1'b1, QUIET},
        // off target: level jumps to the off level, width stays zero
        '{OP_RAMP_TICK,  8'd0,   8'd0,   1'b0, 1'b1, QUIET},
        // levels just above and below the off level
        '{OP_RAMP_TICK,  8'd255, 8'd1,   1'b0, 1'b0, '0},
        '{OP_RAMP_TICK,  8'd255, 8'd200, 1'b1, 1'b0, '0},
        '{OP_ZERO_CROSS, 8'd0,   8'd0,   1'b0, 1'b0, '0},
        // walk the fire window of both channels
        '{OP_PHASE_TICK, 8'd0,   8'd0,   1'b0, 1'b0, '0},
        '{OP_PHASE_TICK, 8'd255, 8'd0,   1'b1, 1'b0, '0},
        '{OP_PHASE_TICK, 8'd0,   8'd255, 1'b0, 1'b0, '0},
        '{OP_PHASE_TICK, 8'd0,   8'd0,   1'b1, 1'b0, '0},
        '{OP_PHASE_TICK, 8'd0,   8'd0,   1'b0, 1'b0, '0},
        '{OP_PHASE_TICK, 8'd0,   8'd0,   1'b1, 1'b0, '0},
        '{OP_PHASE_TICK, 8'd0,   8'd0,   1'b0, 1'b0, '0},
        '{OP_PHASE_TICK, 8'd0,   8'd0,   1'b1, 1'b0, '0},
        '{OP_PHASE_TICK, 8'd0,   8'd0,   1'b0, 1'b0, '0},
        '{OP_PHASE_TICK, 8'd0,   8'd0,   1'b1, 1'b0, '0},
        '{OP_PHASE_TICK, 8'd0,   8'd0,   1'b0, 1'b0, '0},
        '{OP_PHASE_TICK, 8'd0,   8'd0,   1'b1, 1'b0, '0},
        // cross while the relay delay is still running
        '{OP_ZERO_CROSS, 8'd170, 8'd85,  1'b1, 1'b0, '0},
        '{OP_RAMP_TICK,  8'd1,   8'd255, 1'b0, 1'b0, '0},
        '{OP_WATCHDOG,   8'd255, 8'd255, 1'b1, 1'b0, '0},
        '{OP_RAMP_TICK,  8'd0,   8'd255, 1'b0, 1'b0, '0}
    };

    triac_phase_dimmer_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Conduction width from a ramp level, taken modulo 256
    function automatic logic [7:0] width_for_level(input logic [7:0] level);
        int w;
        w = (int'(OFF_LEVEL) - int'(level)) * 2;
        if (level == 8'd0) return 8'd0;
        return w[7:0];
    endfunction

    function automatic logic [7:0] level_step(input logic [7:0] level, input logic [7:0] goal);
        if (level < goal) return level + 8'd1;
        if (level > goal) return level - 8'd1;
        return level;
    endfunction

    // Gate level after a phase tick: low just after fire start, high once the width has passed
    function automatic logic gate_on_tick(input logic [15:0] count, input logic [7:0] start,
                                          input logic [7:0] drive, input logic gate);
        int c;
        int s;
        c = int'(count);
        s = int'(start);
        if (drive == 8'd0) return gate;
        if (c >= s && c < s + int'(LOW_SPAN)) return 1'b0;
        if (c >= s + int'(HIGH_GAP) + int'(drive) && c <= int'(GATE_LIMIT)) return 1'b1;
        return gate;
    endfunction

    // Advance the predicted dimmer by one item and form its result
    task automatic predict_dimmer(input logic [1:0] op, input logic [7:0] tgt_1,
                                  input logic [7:0] tgt_2, input logic blink,
                                  output result_t res);
        logic [7:0] goal_1;
        logic [7:0] goal_2;
        goal_1 = tgt_1;
        goal_2 = tgt_2;
        res    = '0;
        case (op)
            OP_ZERO_CROSS: begin
                dim_gate_1  = 1'b1;
                dim_gate_2  = 1'b1;
                dim_count_1 = '0;
                dim_count_2 = '0;
                if (!dim_relay_armed) begin
                    dim_relay_wait  = '0;
                    dim_relay_armed = 1'b1;
                end
                dim_missed = '0;
            end
            OP_PHASE_TICK: begin
                if (dim_relay_armed) begin
                    dim_relay_wait = dim_relay_wait + 16'd1;
                    if (dim_relay_wait >= set_relay_delay) begin
                        dim_relay_armed  = 1'b0;
                        res.relay_update = 1'b1;
                        if (!blink) begin
                            res.led_write = 1'b1;
                            res.led_level = 1'b1;
                        end
                    end
                end
                dim_count_1 = dim_count_1 + 16'd1;
                dim_count_2 = dim_count_2 + 16'd1;
                dim_gate_1  = gate_on_tick(dim_count_1, set_fire_1, dim_drive_1, dim_gate_1);
                dim_gate_2  = gate_on_tick(dim_count_2, set_fire_2, dim_drive_2, dim_gate_2);
            end
            OP_RAMP_TICK: begin
                // off target forces the level at once, step or not
                if (goal_1 == 8'd0) begin
                    goal_1      = OFF_LEVEL;
                    dim_level_1 = OFF_LEVEL;
                end
                if (goal_2 == 8'd0) begin
                    goal_2      = OFF_LEVEL;
                    dim_level_2 = OFF_LEVEL;
                end
                if (set_ramp_en) begin
                    dim_ramp_div = dim_ramp_div + 8'd1;
                    if (dim_ramp_div >= set_ramp_speed) begin
                        dim_ramp_div = '0;
                        dim_level_1  = level_step(dim_level_1, goal_1);
                        dim_drive_1  = width_for_level(dim_level_1);
                        dim_level_2  = level_step(dim_level_2, goal_2);
                        dim_drive_2  = width_for_level(dim_level_2);
                    end
                end
            end
            OP_WATCHDOG: begin
                dim_missed = dim_missed + 8'd1;
                if (dim_missed > MISS_LIMIT) begin
                    res.relay_update = 1'b1;
                    if (!blink) begin
                        res.led_write = 1'b1;
                        res.led_level = 1'b0;
                    end
                    dim_missed = '0;
                end
            end
        endcase
        res.gate_1  = dim_gate_1;
        res.gate_2  = dim_gate_2;
        res.drive_1 = dim_drive_1;
        res.drive_2 = dim_drive_2;
    endtask

    // Offer one item, record its expected result on acceptance, then maybe idle
    task automatic send_item(input logic [1:0] op, input logic [7:0] tgt_1,
                             input logic [7:0] tgt_2, input logic blink,
                             input logic use_fixed, input result_t fixed);
        result_t     res;
        int unsigned pick;
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, blink, tgt_2, tgt_1};
        do @(posedge aclk); while (!s_tready);
        predict_dimmer(op, tgt_1, tgt_2, blink, res);
        results_due.push_back(use_fixed ? fixed : res);
        gap = 0;
        if (tx_gaps) begin
            pick = $urandom_range(0, 99);
            if (pick >= 92) begin
                gap = $urandom_range(8, 40);
            end else if (pick >= 55) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_RAMP_ENABLE:  set_ramp_en     = value[0];
            REG_RAMP_SPEED:   set_ramp_speed  = value[7:0];
            REG_FIRE_START_1: set_fire_1      = value[7:0];
            REG_FIRE_START_2: set_fire_2      = value[7:0];
            REG_RELAY_DELAY:  set_relay_delay = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] ramp_en, input logic [15:0] speed,
                                  input logic [15:0] fire_1, input logic [15:0] fire_2,
                                  input logic [15:0] delay);
        write_reg(REG_RAMP_ENABLE, ramp_en);
        write_reg(REG_RAMP_SPEED, speed);
        write_reg(REG_FIRE_START_1, fire_1);
        write_reg(REG_FIRE_START_2, fire_2);
        write_reg(REG_RELAY_DELAY, delay);
    endtask

    // Mostly targets near the off level, with some zero targets
    function automatic logic [7:0] pick_target();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return 8'd0;
        if (pick < 70) return 8'($urandom_range(190, 215));
        return 8'($urandom_range(1, 255));
    endfunction

    // Mains-like traffic: zero cross, a few ramp ticks, a run of phase ticks; some noise
    task automatic run_traffic(input int n);
        int sent;
        int ramps;
        int ticks;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 99) < 80) begin
                send_item(OP_ZERO_CROSS, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
                ramps = $urandom_range(0, 2);
                repeat (ramps) begin
                    send_item(OP_RAMP_TICK, pick_target(), pick_target(), 1'($urandom),
                              1'b0, '0);
                end
                ticks = $urandom_range(3, 60);
                repeat (ticks) begin
                    if ($urandom_range(0, 99) < 4) begin
                        send_item(OP_WATCHDOG, 8'($urandom), 8'($urandom), 1'($urandom),
                                  1'b0, '0);
                    end else begin
                        send_item(OP_PHASE_TICK, 8'($urandom), 8'($urandom), 1'($urandom),
                                  1'b0, '0);
                    end
                end
                sent += 1 + ramps + ticks;
            end else begin
                send_item(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            rx_hold   <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (!rx_stalls || $urandom_range(0, 99) < 70) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            rx_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 3);
        end
    end

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            seen_result = m_tdata[$bits(result_t)-1:0];
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("%0t: result with nothing expected, got %h", $time, seen_result);
                end
            end else begin
                oldest_result = results_due.pop_front();
                check_field("gate_1", oldest_result.gate_1, seen_result.gate_1);
                check_field("gate_2", oldest_result.gate_2, seen_result.gate_2);
                check_field("drive_1", oldest_result.drive_1, seen_result.drive_1);
                check_field("drive_2", oldest_result.drive_2, seen_result.drive_2);
                check_field("relay_update", oldest_result.relay_update,
                            seen_result.relay_update);
                check_field("led_write", oldest_result.led_write, seen_result.led_write);
                check_field("led_level", oldest_result.led_level, seen_result.led_level);
            end
        end
    end

    initial begin : stimulus
        int k;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table under reset settings
        for (k = 0; k < N_DIRECTED; k++) begin
            send_item(directed[k].op, directed[k].tgt_1, directed[k].tgt_2,
                      directed[k].blink, directed[k].fixed, directed[k].want);
        end
        wait_results_done();

        // Reset values written back; receiver holds off while the sender keeps offering
        apply_settings(16'd1, 16'd1, 16'd2, 16'd2, 16'd60);
        tx_gaps = 1'b0;
        hold_req <= ~hold_req;
        repeat (20) begin
            send_item(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
        end
        tx_gaps = 1'b1;
        run_traffic(60);
        wait_results_done();

        // Unused indexes are ignored; enable written with upper bits set masks to off
        for (k = int'(REG_RELAY_DELAY) + 1; k < 8; k++) begin
            write_reg(3'(k), 16'($urandom));
        end
        apply_settings(16'hFFFE, 16'd0, 16'd0, 16'd255, 16'd0);
        run_traffic(30);
        wait_results_done();

        // Speed zero and the far extremes, no idling on either side
        apply_settings(16'd1, 16'd0, 16'd255, 16'd0, 16'd65535);
        tx_gaps = 1'b0;
        rx_stalls <= 1'b0;
        run_traffic(40);
        wait_results_done();

        // Slow ramp so the divider holds most ticks
        apply_settings(16'd1, 16'd3, 16'd10, 16'd3, 16'd1);
        tx_gaps = 1'b1;
        rx_stalls <= 1'b1;
        run_traffic(30);
        wait_results_done();

        // No zero cross for long: the watchdog trips
        apply_settings(16'd1, 16'd255, 16'd40, 16'd255, 16'd65535);
        repeat (240) begin
            if ($urandom_range(0, 99) < 95) begin
                send_item(OP_WATCHDOG, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
            end else begin
                send_item(2'($urandom_range(1, 2)), 8'($urandom), 8'($urandom),
                          1'($urandom), 1'b0, '0);
            end
        end
        wait_results_done();

        // Random settings
        apply_settings(16'($urandom), 16'($urandom_range(0, 8)), 16'($urandom_range(0, 40)),
                       16'($urandom_range(0, 40)), 16'($urandom_range(0, 200)));
        run_traffic(40);

        // Drain, then let the pipeline settle
        s_tvalid <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && results_due.size() != 0; k++) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (results_due.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", results_due.size());
        end
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop in case the block hangs
    initial begin : watchdog_timer
        #8000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
